@@ design/rr_pkg.sv @@
// shared types and constants for the fraction reduction block
package rr_pkg;

  localparam int WIDTH = 32;
  localparam int KW = $clog2(WIDTH);
  localparam int CW = $clog2(WIDTH + 1);
  localparam int IN_TDATA_W = ((2 * WIDTH + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((2 * WIDTH - 1 + 7) / 8) * 8;
  localparam int OUT_TUSER_W = 2;

  localparam logic [WIDTH-1:0] MAX_POS = {1'b0, {(WIDTH - 1){1'b1}}};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GCD,
    ST_DIV_N,
    ST_DIV_D,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic gcd_step;
    logic start_n;
    logic start_d;
    logic div_step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic infinite;
    logic gcd_done;
    logic div_done;
    logic out_free;
  } status_t;

endpackage

@@ design/rr_dpath.sv @@
// datapath: magnitudes, binary gcd, shared restoring divider, sign fix and output register
module rr_dpath (
  input  logic                           clk,
  input  logic                           rst,
  input  rr_pkg::cmd_t                   cmd,
  output rr_pkg::status_t                status,
  input  logic [rr_pkg::IN_TDATA_W-1:0]  s_tdata,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [rr_pkg::OUT_TDATA_W-1:0] m_tdata,
  output logic [rr_pkg::OUT_TUSER_W-1:0] m_tuser
);
  import rr_pkg::*;

  logic [WIDTH-1:0] in_num, in_den;
  logic [WIDTH-1:0] mag_num, mag_den;
  logic             sign_n, sign_d, inf;
  logic [WIDTH-1:0] mn, md;
  logic [WIDTH-1:0] ga, gb, g;
  logic [KW-1:0]    k;
  logic [WIDTH-1:0] dq, rem;
  logic [CW-1:0]    cnt;
  logic [WIDTH:0]   rem_shift;
  logic             sub_ok;
  logic [WIDTH-1:0] rn, rd_full;
  logic             neg, ovf;
  logic [WIDTH-1:0] out_num;
  logic [WIDTH-2:0] out_den;
  logic             out_inf, out_ovf;

  assign in_num  = s_tdata[WIDTH-1:0];
  assign in_den  = s_tdata[2*WIDTH-1:WIDTH];
  assign mag_num = in_num[WIDTH-1] ? (~in_num + 1'b1) : in_num;
  assign mag_den = in_den[WIDTH-1] ? (~in_den + 1'b1) : in_den;

  assign rem_shift = {rem, dq[WIDTH-1]};
  assign sub_ok    = rem_shift >= {1'b0, g};

  // gcd state and the shared divider
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sign_n <= in_num[WIDTH-1];
      sign_d <= in_den[WIDTH-1];
      inf    <= (in_den == '0);
      mn     <= mag_num;
      md     <= mag_den;
      ga     <= mag_den;
      gb     <= mag_num;
      k      <= '0;
    end else if (cmd.gcd_step) begin
      if (!ga[0] && !gb[0]) begin
        ga <= ga >> 1;
        gb <= gb >> 1;
        k  <= k + 1'b1;
      end else if (!ga[0]) begin
        ga <= ga >> 1;
      end else if (!gb[0]) begin
        gb <= gb >> 1;
      end else if (ga >= gb) begin
        ga <= ga - gb;
      end else begin
        gb <= gb - ga;
      end
    end
    if (cmd.start_n) begin
      g   <= ga | gb;
      dq  <= mn >> k;
      rem <= '0;
      cnt <= CW'(WIDTH);
    end else if (cmd.start_d) begin
      mn  <= dq;
      dq  <= md >> k;
      rem <= '0;
      cnt <= CW'(WIDTH);
    end else if (cmd.div_step) begin
      rem <= sub_ok ? WIDTH'(rem_shift - {1'b0, g}) : rem_shift[WIDTH-1:0];
      dq  <= {dq[WIDTH-2:0], sub_ok};
      cnt <= cnt - 1'b1;
    end
  end

  // sign fix and saturation, mn holds numerator quotient, dq holds denominator quotient
  always_comb begin
    neg = (mn != '0) && (sign_n != sign_d);
    ovf = 1'b0;
    if (neg) begin
      rn = ~mn + 1'b1;
    end else if (mn[WIDTH-1]) begin
      rn  = MAX_POS;
      ovf = 1'b1;
    end else begin
      rn = mn;
    end
    if (dq[WIDTH-1]) begin
      rd_full = MAX_POS;
      ovf     = 1'b1;
    end else begin
      rd_full = dq;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.finish) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      if (inf) begin
        out_num <= '0;
        out_den <= '0;
        out_inf <= 1'b1;
        out_ovf <= 1'b0;
      end else begin
        out_num <= rn;
        out_den <= rd_full[WIDTH-2:0];
        out_inf <= 1'b0;
        out_ovf <= ovf;
      end
    end
  end

  assign m_tdata = OUT_TDATA_W'({out_den, out_num});
  assign m_tuser = {out_ovf, out_inf};

  assign status.infinite = inf;
  assign status.gcd_done = (ga == '0) || (gb == '0);
  assign status.div_done = (cnt == '0);
  assign status.out_free = !m_tvalid || m_tready;

endmodule

@@ design/rr_ctrl.sv @@
// controller state machine sequencing gcd, two divisions and output load
module rr_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  output logic            s_tready,
  input  rr_pkg::status_t status,
  output rr_pkg::cmd_t    cmd
);
  import rr_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = ST_GCD;
        end
      end
      ST_GCD: begin
        if (status.infinite) begin
          state_next = ST_DONE;
        end else if (status.gcd_done) begin
          cmd.start_n = 1'b1;
          state_next  = ST_DIV_N;
        end else begin
          cmd.gcd_step = 1'b1;
        end
      end
      ST_DIV_N: begin
        if (status.div_done) begin
          cmd.start_d = 1'b1;
          state_next  = ST_DIV_D;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      ST_DIV_D: begin
        if (status.div_done) begin
          state_next = ST_DONE;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      ST_DONE: begin
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

@@ design/rational_reduce.sv @@
// top level: reduces a signed fraction to lowest terms with a positive denominator
//
// input channel s_*: one item is a numerator and a denominator, both two's
// complement; an item is taken when s_tvalid and s_tready are high together.
// output channel m_*: one result item for every input item, in order.
// a zero denominator gives 0/0 with is_infinite set; a part that cannot be
// made to fit after moving the sign is saturated and overflow is set.
// one item is worked on at a time: a binary gcd loop runs shift or subtract
// steps until one operand reaches zero, then one shared restoring divider
// runs for the numerator and again for the denominator. a zero denominator
// skips the gcd loop and both divisions.
// the result sits in an output register, so the next item is accepted while
// it waits; if the receiver stalls, the following result holds in the
// controller until the output register frees.
// rst is synchronous and active high; it empties the output register and
// returns the controller to idle.
module rational_reduce (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [rr_pkg::IN_TDATA_W-1:0]  s_tdata,  // numerator, denominator
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [rr_pkg::OUT_TDATA_W-1:0] m_tdata,  // reduced_numerator, reduced_denominator
  output logic [rr_pkg::OUT_TUSER_W-1:0] m_tuser   // is_infinite, overflow
);
  import rr_pkg::*;

  cmd_t    cmd;
  status_t status;

  rr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  rr_dpath u_dpath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .status   (status),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

@@ tb/sv/tb_rational_reduce.sv @@
// testbench for rational_reduce: predicts each reduced fraction and checks every result item
`timescale 1ns / 100ps

module tb_rational_reduce;
  import rr_pkg::*;

  typedef struct {
    logic [WIDTH-1:0] num;
    logic [WIDTH-2:0] den;
    logic             inf;
    logic             ovf;
  } reduced_t;

  localparam logic [WIDTH-1:0] MOST_NEG = {1'b1, {(WIDTH - 1){1'b0}}};

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic [OUT_TUSER_W-1:0] m_tuser;

  reduced_t reduced_q[$];
  int       err_cnt = 0;
  int       hold_off_cycles = 0;
  bit       idle_on = 1'b1;

  rational_reduce dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [WIDTH-1:0] abs_value(logic [WIDTH-1:0] v);
    return v[WIDTH-1] ? (~v + 1'b1) : v;
  endfunction

  function automatic reduced_t reduce_fraction(logic [WIDTH-1:0] n, logic [WIDTH-1:0] d);
    reduced_t         r;
    logic [WIDTH-1:0] a, b, t, mn, md;
    logic             neg;
    r.num = '0;
    r.den = '0;
    r.inf = 1'b0;
    r.ovf = 1'b0;
    if (d == '0) begin
      r.inf = 1'b1;
      return r;
    end
    mn = abs_value(n);
    md = abs_value(d);
    a = md;
    b = mn;
    while (b != '0) begin
      t = a % b;
      a = b;
      b = t;
    end
    mn = mn / a;
    md = md / a;
    neg = (mn != '0) && (n[WIDTH-1] != d[WIDTH-1]);
    if (neg) begin
      r.num = ~mn + 1'b1;
    end else if (mn > MAX_POS) begin
      r.num = MAX_POS;
      r.ovf = 1'b1;
    end else begin
      r.num = mn;
    end
    if (md > MAX_POS) begin
      r.den = MAX_POS[WIDTH-2:0];
      r.ovf = 1'b1;
    end else begin
      r.den = md[WIDTH-2:0];
    end
    return r;
  endfunction

  function automatic int pick_gap();
    int roll;
    if (!idle_on) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 65) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 20);
    return $urandom_range(50, 250);
  endfunction

  task automatic send_item(logic [WIDTH-1:0] n, logic [WIDTH-1:0] d);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= IN_TDATA_W'({d, n});
    do @(posedge clk); while (!s_tready);
    reduced_q.push_back(reduce_fraction(n, d));
  endtask

  task automatic wait_results();
    s_tvalid <= 1'b0;
    while (reduced_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic check_result();
    reduced_t e;
    if (reduced_q.size() == 0) begin
      $error("unexpected result item tdata=%h tuser=%b", m_tdata, m_tuser);
      err_cnt++;
      return;
    end
    e = reduced_q.pop_front();
    if (m_tdata[WIDTH-1:0] !== e.num) begin
      $error("reduced_numerator: expected %h, got %h", e.num, m_tdata[WIDTH-1:0]);
      err_cnt++;
    end
    if (m_tdata[2*WIDTH-2:WIDTH] !== e.den) begin
      $error("reduced_denominator: expected %h, got %h", e.den, m_tdata[2*WIDTH-2:WIDTH]);
      err_cnt++;
    end
    if (m_tuser[0] !== e.inf) begin
      $error("is_infinite: expected %b, got %b", e.inf, m_tuser[0]);
      err_cnt++;
    end
    if (m_tuser[1] !== e.ovf) begin
      $error("overflow: expected %b, got %b", e.ovf, m_tuser[1]);
      err_cnt++;
    end
  endtask

  initial begin : receiver
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (rst) begin
        m_tready <= 1'b0;
      end else begin
        if (m_tvalid && m_tready) check_result();
        if (hold_off_cycles > 0) begin
          hold_off_cycles--;
          m_tready <= 1'b0;
        end else if (stall_left > 0) begin
          stall_left--;
          m_tready <= 1'b0;
        end else begin
          m_tready <= 1'b1;
          if (idle_on && $urandom_range(0, 2) == 0) stall_left = pick_gap();
        end
      end
    end
  end

  function automatic logic [WIDTH-1:0] random_part();
    int               kind;
    logic [WIDTH-1:0] v;
    kind = $urandom_range(0, 9);
    case (kind)
      0, 1, 2: v = $urandom();
      3: v = $urandom_range(0, 200);
      4: v = -$urandom_range(1, 200);
      5: v = {{(WIDTH - 1){1'b0}}, 1'b1} << $urandom_range(0, WIDTH - 1);
      6: v = MOST_NEG;
      7: v = MAX_POS - $urandom_range(0, 3);
      default: v = $urandom() >> $urandom_range(0, WIDTH - 1);
    endcase
    if ($urandom_range(0, 3) == 0) v = -v;
    return v;
  endfunction

  task automatic test_extremes();
    send_item(0, 1);
    send_item(0, -1);
    send_item(0, 0);
    send_item(5, 0);
    send_item(MOST_NEG, 0);
    send_item(MAX_POS, 0);
    send_item(MOST_NEG, -1);
    send_item(MOST_NEG, MOST_NEG);
    send_item(MOST_NEG, 1);
    send_item(1, MOST_NEG);
    send_item(-1, MOST_NEG);
    send_item(0, MOST_NEG);
    send_item(MAX_POS, MAX_POS);
    send_item(MAX_POS, MOST_NEG);
    send_item(MOST_NEG, MAX_POS);
    send_item(6, -4);
    send_item(-6, -4);
    send_item(12, 18);
    send_item(MAX_POS, 1);
    send_item(-1, -1);
    send_item(1, -1);
    send_item(MOST_NEG, 2);
    send_item(MOST_NEG, -2);
    send_item(7, 13);
    send_item(32'h4000_0000, 32'h0010_0000);
  endtask

  task automatic test_random(int count);
    logic [WIDTH-1:0] n, d, k;
    repeat (count) begin
      case ($urandom_range(0, 5))
        0, 1: begin
          n = random_part();
          d = random_part();
        end
        2, 3: begin
          k = $urandom_range(1, 1 << 14);
          n = k * $urandom_range(0, 1 << 16);
          d = k * $urandom_range(1, 1 << 16);
          if ($urandom_range(0, 1)) n = -n;
          if ($urandom_range(0, 1)) d = -d;
        end
        4: begin
          n = $urandom();
          d = $urandom();
        end
        default: begin
          n = random_part();
          d = ($urandom_range(0, 1)) ? '0 : MOST_NEG;
        end
      endcase
      send_item(n, d);
    end
  endtask

  task automatic test_backpressure();
    hold_off_cycles = 1500;
    idle_on = 1'b0;
    test_random(12);
    idle_on = 1'b1;
  endtask

  task automatic test_no_idle();
    idle_on = 1'b0;
    test_random(60);
    idle_on = 1'b1;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_extremes();
    wait_results();
    test_random(650);
    wait_results();
    test_backpressure();
    wait_results();
    test_no_idle();
    wait_results();
    test_random(60);
    wait_results();
    if (err_cnt == 0 && reduced_q.size() == 0) begin
      $display("tb_rational_reduce: clean");
    end else begin
      $display("tb_rational_reduce: errors");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("tb_rational_reduce: errors");
    $finish;
  end

endmodule
